>>> src/zoq_pkg.sv
// ----------------------------------------------------------------------------
// zoq_pkg: shared types and constants for the zone occupancy queue detector
// Frame size limits, derived widths, the divide-by-255 reciprocal, the
// register map and the records passed between the front, the frame queue
// and the back.
// ----------------------------------------------------------------------------
package zoq_pkg;

  // Longest frame that is counted exactly; longer frames saturate.
  localparam int unsigned MAX_PIXELS = 1048576;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PLIM_W  = 8;
  localparam int unsigned QLIM_W  = 10;
  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned NUM_PC  = 4;

  localparam int unsigned CNT_W   = $clog2(MAX_PIXELS + 1);
  localparam logic [63:0] SUM_MAX = 64'd255 * 64'(MAX_PIXELS);
  localparam int unsigned SUM_W   = $clog2(SUM_MAX + 64'd1);

  localparam logic [CNT_W-1:0] CNT_MAX_V = CNT_W'(MAX_PIXELS);
  localparam logic [SUM_W-1:0] SUM_MAX_V = SUM_W'(SUM_MAX);

  // floor(sum/255) = (sum * RECIP) >> RECIP_SH, exact for every sum < 2**SUM_W
  localparam int unsigned RECIP_SH = SUM_W + 8;
  localparam int unsigned RECIP_W  = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd254) / 64'd255);

  // threshold products pct*count and occupancy*100
  localparam int unsigned PROD_W = CNT_W + PCT_W;

  // frame queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // configuration register map
  typedef enum logic [2:0] {
    REG_PRE_PCT_A     = 3'd0,
    REG_POST_PCT_A    = 3'd1,
    REG_PRE_PCT_B     = 3'd2,
    REG_POST_PCT_B    = 3'd3,
    REG_PERSIST_LIMIT = 3'd4,
    REG_QUEUE_LIMIT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_W-1:0] pre_sum;
    logic [CNT_W-1:0] pre_cnt;
    logic [SUM_W-1:0] post_sum;
    logic [CNT_W-1:0] post_cnt;
  } frame_rec_t;

  typedef struct packed {
    logic [PCT_W-1:0]  pre_pct_a;
    logic [PCT_W-1:0]  post_pct_a;
    logic [PCT_W-1:0]  pre_pct_b;
    logic [PCT_W-1:0]  post_pct_b;
    logic [PLIM_W-1:0] persist_limit;
    logic [QLIM_W-1:0] queue_limit;
  } cfg_t;

endpackage

>>> src/zoq_front.sv
// ----------------------------------------------------------------------------
// zoq_front: per-frame zone accumulator
// Sums pixel values and counts mask pixels for both zones; on the last pixel
// of a frame it emits the frame totals and clears for the next frame.
// ----------------------------------------------------------------------------
module zoq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [zoq_pkg::PIX_W-1:0]     pixel_value,
  input  logic                          in_pre_zone,
  input  logic                          in_post_zone,
  input  logic                          end_of_frame,
  output logic                          rec_push,
  output zoq_pkg::frame_rec_t           rec
);

  logic [zoq_pkg::SUM_W-1:0] pre_sum_r, pre_sum_nxt, post_sum_r, post_sum_nxt;
  logic [zoq_pkg::CNT_W-1:0] pre_cnt_r, pre_cnt_nxt, post_cnt_r, post_cnt_nxt;

  function automatic logic [zoq_pkg::SUM_W-1:0] sat_add(
    input logic [zoq_pkg::SUM_W-1:0] s,
    input logic [zoq_pkg::PIX_W-1:0] p
  );
    logic [zoq_pkg::SUM_W:0] t;
    t = {1'b0, s} + (zoq_pkg::SUM_W + 1)'(p);
    if (t > {1'b0, zoq_pkg::SUM_MAX_V}) return zoq_pkg::SUM_MAX_V;
    return t[zoq_pkg::SUM_W-1:0];
  endfunction

  function automatic logic [zoq_pkg::CNT_W-1:0] sat_inc(
    input logic [zoq_pkg::CNT_W-1:0] c
  );
    return (c < zoq_pkg::CNT_MAX_V) ? c + 1'b1 : c;
  endfunction

  always_comb begin
    pre_sum_nxt  = pre_sum_r;
    pre_cnt_nxt  = pre_cnt_r;
    post_sum_nxt = post_sum_r;
    post_cnt_nxt = post_cnt_r;
    if (in_pre_zone) begin
      pre_sum_nxt = sat_add(pre_sum_r, pixel_value);
      pre_cnt_nxt = sat_inc(pre_cnt_r);
    end
    if (in_post_zone) begin
      post_sum_nxt = sat_add(post_sum_r, pixel_value);
      post_cnt_nxt = sat_inc(post_cnt_r);
    end
  end

  // totals include the last pixel itself
  assign rec_push      = acc && end_of_frame;
  assign rec.pre_sum   = pre_sum_nxt;
  assign rec.pre_cnt   = pre_cnt_nxt;
  assign rec.post_sum  = post_sum_nxt;
  assign rec.post_cnt  = post_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_sum_r  <= '0;
      pre_cnt_r  <= '0;
      post_sum_r <= '0;
      post_cnt_r <= '0;
    end else if (acc) begin
      if (end_of_frame) begin
        pre_sum_r  <= '0;
        pre_cnt_r  <= '0;
        post_sum_r <= '0;
        post_cnt_r <= '0;
      end else begin
        pre_sum_r  <= pre_sum_nxt;
        pre_cnt_r  <= pre_cnt_nxt;
        post_sum_r <= post_sum_nxt;
        post_cnt_r <= post_cnt_nxt;
      end
    end
  end

endmodule

>>> src/zoq_fifo.sv
// ----------------------------------------------------------------------------
// zoq_fifo: frame record queue
// Small FIFO between the accumulator and the decision pipeline.
// ----------------------------------------------------------------------------
module zoq_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  zoq_pkg::frame_rec_t           wdata,
  input  logic                          pop,
  output zoq_pkg::frame_rec_t           rdata,
  output logic                          not_empty,
  output logic                          full,
  output logic [zoq_pkg::FIFO_CW-1:0]   level
);

  zoq_pkg::frame_rec_t             mem_r [zoq_pkg::FIFO_DEPTH];
  logic [zoq_pkg::FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [zoq_pkg::FIFO_CW-1:0]     cnt_r;

  assign rdata     = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == zoq_pkg::FIFO_CW'(zoq_pkg::FIFO_DEPTH));
  assign level     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> src/zoq_back.sv
// ----------------------------------------------------------------------------
// zoq_back: frame decision pipeline
// Three stages: occupancy and threshold products, density compare, then the
// persistence and queue level update that also forms the result register.
// ----------------------------------------------------------------------------
module zoq_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  zoq_pkg::cfg_t                   cfg,
  input  logic                            rec_valid,
  input  zoq_pkg::frame_rec_t             rec,
  output logic                            rec_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            queue_full,
  output logic [zoq_pkg::LEVEL_W-1:0]     queue_level,
  output logic                            case_a_persistent,
  output logic                            case_b_persistent
);

  localparam int unsigned MUL_W = zoq_pkg::SUM_W + zoq_pkg::RECIP_W;

  logic                            en;
  logic [MUL_W-1:0]                pre_prod, post_prod;

  // stage 1
  logic                            s1_valid_r;
  logic [zoq_pkg::CNT_W-1:0]       s1_pre_occ_r, s1_post_occ_r;
  logic [zoq_pkg::PROD_W-1:0]      s1_thr_r [zoq_pkg::NUM_PC];
  logic                            s1_pre_nz_r, s1_post_nz_r;
  // stage 2
  logic                            s2_valid_r;
  logic [zoq_pkg::NUM_PC-1:0]      s2_dense_r;
  logic [zoq_pkg::NUM_PC-1:0]      dense_nxt;
  logic [zoq_pkg::PROD_W-1:0]      pre_occ100, post_occ100;
  // stage 3 / state
  logic                            out_valid_r;
  logic [zoq_pkg::PLIM_W-1:0]      pc_r   [zoq_pkg::NUM_PC];
  logic [zoq_pkg::PLIM_W-1:0]      pc_nxt [zoq_pkg::NUM_PC];
  logic [zoq_pkg::LEVEL_W-1:0]     level_r, level_nxt, cap;
  logic                            a_pers, b_pers;
  logic                            full_r, a_r, b_r;

  assign en      = !out_valid_r || out_ready;
  assign rec_pop = en && rec_valid;

  assign pre_prod  = MUL_W'(rec.pre_sum)  * MUL_W'(zoq_pkg::RECIP);
  assign post_prod = MUL_W'(rec.post_sum) * MUL_W'(zoq_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pre_occ_r  <= pre_prod[zoq_pkg::RECIP_SH +: zoq_pkg::CNT_W];
      s1_post_occ_r <= post_prod[zoq_pkg::RECIP_SH +: zoq_pkg::CNT_W];
      s1_pre_nz_r   <= (rec.pre_cnt != '0);
      s1_post_nz_r  <= (rec.post_cnt != '0);
      s1_thr_r[0]   <= zoq_pkg::PROD_W'(cfg.pre_pct_a)  * zoq_pkg::PROD_W'(rec.pre_cnt);
      s1_thr_r[1]   <= zoq_pkg::PROD_W'(cfg.post_pct_a) * zoq_pkg::PROD_W'(rec.post_cnt);
      s1_thr_r[2]   <= zoq_pkg::PROD_W'(cfg.pre_pct_b)  * zoq_pkg::PROD_W'(rec.pre_cnt);
      s1_thr_r[3]   <= zoq_pkg::PROD_W'(cfg.post_pct_b) * zoq_pkg::PROD_W'(rec.post_cnt);
    end
  end

  // dense: occupancy*100 > pct*count, never for an empty zone
  assign pre_occ100  = zoq_pkg::PROD_W'(s1_pre_occ_r)  * zoq_pkg::PROD_W'(100);
  assign post_occ100 = zoq_pkg::PROD_W'(s1_post_occ_r) * zoq_pkg::PROD_W'(100);

  always_comb begin
    dense_nxt[0] = s1_pre_nz_r  && (pre_occ100  > s1_thr_r[0]);
    dense_nxt[1] = s1_post_nz_r && (post_occ100 > s1_thr_r[1]);
    dense_nxt[2] = s1_pre_nz_r  && (pre_occ100  > s1_thr_r[2]);
    dense_nxt[3] = s1_post_nz_r && (post_occ100 > s1_thr_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dense_r <= dense_nxt;
    end
  end

  // counters: A pre, A post, B pre, B post
  always_comb begin
    for (int i = 0; i < zoq_pkg::NUM_PC; i++) begin
      if (s2_dense_r[i]) begin
        pc_nxt[i] = (pc_r[i] < cfg.persist_limit) ? pc_r[i] + 1'b1 : pc_r[i];
      end else begin
        pc_nxt[i] = (pc_r[i] >= zoq_pkg::PLIM_W'(2)) ? pc_r[i] - zoq_pkg::PLIM_W'(2) : '0;
      end
    end
    a_pers = (pc_nxt[0] >= cfg.persist_limit) && (pc_nxt[1] >= cfg.persist_limit);
    b_pers = (pc_nxt[2] >= cfg.persist_limit) && (pc_nxt[3] >= cfg.persist_limit);
    cap    = {cfg.queue_limit, 2'b00};
    level_nxt = level_r;
    if (a_pers || b_pers) begin
      if (level_r < cap) level_nxt = level_r + 1'b1;
    end else begin
      if (level_r != '0) level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      level_r     <= '0;
      for (int i = 0; i < zoq_pkg::NUM_PC; i++) pc_r[i] <= '0;
    end else if (en) begin
      out_valid_r <= s2_valid_r;
      if (s2_valid_r) begin
        level_r <= level_nxt;
        for (int i = 0; i < zoq_pkg::NUM_PC; i++) pc_r[i] <= pc_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid_r) begin
      full_r <= (level_nxt > zoq_pkg::LEVEL_W'(cfg.queue_limit));
      a_r    <= a_pers;
      b_r    <= b_pers;
    end
  end

  assign out_valid         = out_valid_r;
  assign queue_full        = full_r;
  assign queue_level       = level_r;
  assign case_a_persistent = a_r;
  assign case_b_persistent = b_r;

endmodule

>>> src/zone_occupancy_queue_detector.sv
// ----------------------------------------------------------------------------
// zone_occupancy_queue_detector: frame-level queue detector on a pixel stream
// Zone density per frame, persistence filtering and a queue level counter.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock with no gaps of its own: in_tready
// drops only when four finished frames wait in the frame queue, which can
// happen only when the result side is stalled. Each pixel with in_tlast set
// closes a frame and yields exactly one result transaction; out_tvalid rises
// after the frame queue write, occupancy/threshold multiply, density compare
// and counter update into the result register; the later steps stall on
// out_tready. The decision pipeline takes one frame per cycle, so even frames
// of a single pixel stream at full rate while out_tready is high. Occupancy
// per zone is floor(sum/255), computed with a reciprocal multiply; counts
// saturate at MAX_PIXELS pixels per frame. Configuration must be written
// through the cfg_ port while no frame is in flight, which the block does not
// enforce; cfg_ready is always high and writes to unused indexes are ignored.
// ----------------------------------------------------------------------------
module zone_occupancy_queue_detector (
  input  logic        clk,
  input  logic        rst_n,
  // pixel stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_value
  input  logic [1:0]  in_tuser,   // [0] in_pre_zone, [1] in_post_zone
  input  logic        in_tlast,   // end_of_frame
  // frame results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] queue_full, [12:1] queue_level,
                                  // [13] case_a_persistent,
                                  // [14] case_b_persistent, [15] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  zoq_pkg::cfg_t                 cfg_r;
  logic                          acc;
  logic                          fifo_push, fifo_pop, fifo_ne, fifo_full;
  logic [zoq_pkg::FIFO_CW-1:0]   fifo_level;
  zoq_pkg::frame_rec_t           front_rec, fifo_rec;
  logic                          res_full, res_a, res_b;
  logic [zoq_pkg::LEVEL_W-1:0]   res_level;

  // ---- configuration registers ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_pct_a     <= zoq_pkg::PCT_W'(40);
      cfg_r.post_pct_a    <= zoq_pkg::PCT_W'(10);
      cfg_r.pre_pct_b     <= zoq_pkg::PCT_W'(20);
      cfg_r.post_pct_b    <= zoq_pkg::PCT_W'(20);
      cfg_r.persist_limit <= zoq_pkg::PLIM_W'(10);
      cfg_r.queue_limit   <= zoq_pkg::QLIM_W'(25);
    end else if (cfg_valid && cfg_ready) begin
      case (zoq_pkg::cfg_reg_t'(cfg_index))
        zoq_pkg::REG_PRE_PCT_A:
          cfg_r.pre_pct_a     <= cfg_data[zoq_pkg::PCT_W-1:0];
        zoq_pkg::REG_POST_PCT_A:
          cfg_r.post_pct_a    <= cfg_data[zoq_pkg::PCT_W-1:0];
        zoq_pkg::REG_PRE_PCT_B:
          cfg_r.pre_pct_b     <= cfg_data[zoq_pkg::PCT_W-1:0];
        zoq_pkg::REG_POST_PCT_B:
          cfg_r.post_pct_b    <= cfg_data[zoq_pkg::PCT_W-1:0];
        zoq_pkg::REG_PERSIST_LIMIT:
          cfg_r.persist_limit <= cfg_data[zoq_pkg::PLIM_W-1:0];
        zoq_pkg::REG_QUEUE_LIMIT:
          cfg_r.queue_limit   <= cfg_data[zoq_pkg::QLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- front: accumulate, one pixel per clock while in_tready is high ----
  // Ready does not look at tlast, so a full queue stalls every pixel.
  assign in_tready = !fifo_full;
  assign acc       = in_tvalid && in_tready;

  zoq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .pixel_value  (in_tdata),
    .in_pre_zone  (in_tuser[0]),
    .in_post_zone (in_tuser[1]),
    .end_of_frame (in_tlast),
    .rec_push     (fifo_push),
    .rec          (front_rec)
  );

  // ---- frame queue ----
  zoq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .wdata     (front_rec),
    .pop       (fifo_pop),
    .rdata     (fifo_rec),
    .not_empty (fifo_ne),
    .full      (fifo_full),
    .level     (fifo_level)
  );

  // ---- back: decision pipeline and result register ----
  zoq_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .rec_valid         (fifo_ne),
    .rec               (fifo_rec),
    .rec_pop           (fifo_pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .queue_full        (res_full),
    .queue_level       (res_level),
    .case_a_persistent (res_a),
    .case_b_persistent (res_b)
  );

  assign out_tdata = {1'b0, res_b, res_a, res_level, res_full};

  // ---- assertions ----
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_full)
    else $error("frame queue written while full");

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_push && !fifo_pop) |=> (fifo_level == $past(fifo_level) + 1'b1))
    else $error("frame queue count lost a record");

  a_full_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res_level == '0)) |-> !res_full)
    else $error("queue full reported with empty level");

endmodule
